### design/wfpi_pkg.sv
// Shared types and constants for the wall-following PI controller.
package wfpi_pkg;

    // Phase codes reported with every result
    localparam logic [1:0] PHASE_WAIT     = 2'd0;
    localparam logic [1:0] PHASE_APPROACH = 2'd1;
    localparam logic [1:0] PHASE_FOLLOW   = 2'd2;
    localparam logic [1:0] PHASE_AVOID    = 2'd3;

    // Register indexes on the APB port
    localparam logic [1:0] REG_WALL_SETPOINT  = 2'd0;
    localparam logic [1:0] REG_SLOW_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_GAIN_PROP      = 2'd2;
    localparam logic [1:0] REG_GAIN_INTEG     = 2'd3;

    localparam logic [15:0] WALL_SETPOINT_RST  = 16'd819;
    localparam logic [15:0] SLOW_THRESHOLD_RST = 16'd2048;

    // Q4.12 distance thresholds
    localparam logic [15:0] FRONT_NEAR  = 16'd1638;
    localparam logic [15:0] FRONT_CLEAR = 16'd2457;

    // Q0.12 speed commands
    localparam logic [11:0] SPEED_ZERO     = 12'd0;
    localparam logic [11:0] SPEED_APPROACH = 12'd2458;
    localparam logic [11:0] SPEED_SLOW     = 12'd205;
    localparam logic [11:0] SPEED_FAST     = 12'd287;
    localparam logic [11:0] SPEED_CRAWL    = 12'd1;

    // Turn rates, Q12 rad/s
    localparam logic signed [23:0] TURN_RATE = 24'sd64340;
    localparam logic signed [23:0] ANG_ZERO  = 24'sd0;
    localparam logic signed [23:0] ANG_MAX   = 24'sh7FFFFF;
    localparam logic signed [23:0] ANG_MIN   = 24'sh800000;

    // Divide by ten: n/10 = (n * RECIP_TEN) >> 35 for any 32-bit n
    localparam logic [31:0] RECIP_TEN       = 32'hCCCCCCCD;
    // Small divide by ten: x/10 = (x * RECIP_TEN_SMALL) >> 16 for x below 16384
    localparam logic [12:0] RECIP_TEN_SMALL = 13'd6554;

    typedef struct packed {
        logic [15:0] front_range;
        logic [15:0] right_range;
    } in_req_t;

    typedef struct packed {
        logic [11:0]        linear_speed;
        logic signed [23:0] angular_speed;
        logic [1:0]         phase;
    } out_req_t;

    typedef struct packed {
        logic [15:0]       wall_setpoint;
        logic [15:0]       slow_threshold;
        logic signed [7:0] gain_prop;
        logic signed [7:0] gain_integ;
    } cfg_t;

    // Request handed from the phase stage to the control-law pipeline
    typedef struct packed {
        logic [11:0]        linear_speed;
        logic [1:0]         phase;
        logic signed [16:0] err;
        logic signed [31:0] sum;
    } law_req_t;

endpackage

### design/wfpi_regs.sv
// APB configuration registers of the wall-following controller.
module wfpi_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output wfpi_pkg::cfg_t    cfg
);

    wfpi_pkg::cfg_t cfg_reg;
    wfpi_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                wfpi_pkg::REG_WALL_SETPOINT:  cfg_next.wall_setpoint  = pwdata[15:0];
                wfpi_pkg::REG_SLOW_THRESHOLD: cfg_next.slow_threshold = pwdata[15:0];
                wfpi_pkg::REG_GAIN_PROP:      cfg_next.gain_prop      = $signed(pwdata[7:0]);
                wfpi_pkg::REG_GAIN_INTEG:     cfg_next.gain_integ     = $signed(pwdata[7:0]);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wall_setpoint  <= wfpi_pkg::WALL_SETPOINT_RST;
            cfg_reg.slow_threshold <= wfpi_pkg::SLOW_THRESHOLD_RST;
            cfg_reg.gain_prop      <= 8'sd0;
            cfg_reg.gain_integ     <= 8'sd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux, gains sign-extended
    always_comb
    begin
        unique case (paddr[3:2])
            wfpi_pkg::REG_WALL_SETPOINT:  prdata = {16'd0, cfg_reg.wall_setpoint};
            wfpi_pkg::REG_SLOW_THRESHOLD: prdata = {16'd0, cfg_reg.slow_threshold};
            wfpi_pkg::REG_GAIN_PROP:      prdata = 32'(cfg_reg.gain_prop);
            wfpi_pkg::REG_GAIN_INTEG:     prdata = 32'(cfg_reg.gain_integ);
        endcase
    end

endmodule

### design/wfpi_ctrl.sv
// Input register, phase decision and controller state (startup count, flag, error sum).
module wfpi_ctrl
#(
    parameter logic [11:0] STARTUP_CNT = 12'd300
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  wfpi_pkg::in_req_t   in_data,
    input  wfpi_pkg::cfg_t      cfg,
    input  logic                law_ready,
    output logic                law_valid,
    output wfpi_pkg::law_req_t  law_req
);

    logic               valid_reg;
    logic               valid_next;
    wfpi_pkg::in_req_t  req_reg;
    logic               started_reg;
    logic               started_next;
    logic [11:0]        wait_count_reg;
    logic [11:0]        wait_count_next;
    logic signed [31:0] error_sum_reg;
    logic signed [31:0] error_sum_next;

    logic               fire;
    logic               accept;
    logic signed [16:0] err;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;

    assign in_stall  = valid_reg && !law_ready;
    assign accept    = in_valid && !in_stall;
    assign fire      = valid_reg && law_ready;
    assign law_valid = valid_reg;

    // Wall error and saturating integral
    assign err      = $signed({1'b0, cfg.wall_setpoint}) - $signed({1'b0, req_reg.right_range});
    assign sum_wide = 33'(error_sum_reg) + 33'(err);

    always_comb
    begin
        priority if (sum_wide[32] == sum_wide[31])
            sum_sat = sum_wide[31:0];
        else if (sum_wide[32])
            sum_sat = 32'sh80000000;
        else
            sum_sat = 32'sh7FFFFFFF;
    end

    // Phase decision and state update
    always_comb
    begin
        started_next         = started_reg;
        wait_count_next      = wait_count_reg;
        error_sum_next       = error_sum_reg;
        law_req.err          = err;
        law_req.sum          = sum_sat;
        law_req.linear_speed = wfpi_pkg::SPEED_ZERO;
        law_req.phase        = wfpi_pkg::PHASE_WAIT;

        priority if (!started_reg)
        begin
            priority if (wait_count_reg < STARTUP_CNT)
            begin
                wait_count_next = wait_count_reg + 12'd1;
            end
            else if (req_reg.front_range > wfpi_pkg::FRONT_NEAR)
            begin
                law_req.linear_speed = wfpi_pkg::SPEED_APPROACH;
                law_req.phase        = wfpi_pkg::PHASE_APPROACH;
            end
            else
            begin
                started_next  = 1'b1;
                law_req.phase = wfpi_pkg::PHASE_APPROACH;
            end
        end
        else if (req_reg.front_range > wfpi_pkg::FRONT_CLEAR)
        begin
            error_sum_next       = sum_sat;
            law_req.phase        = wfpi_pkg::PHASE_FOLLOW;
            law_req.linear_speed = (req_reg.front_range < cfg.slow_threshold) ?
                                   wfpi_pkg::SPEED_SLOW : wfpi_pkg::SPEED_FAST;
        end
        else
        begin
            error_sum_next       = 32'sd0;
            law_req.phase        = wfpi_pkg::PHASE_AVOID;
            law_req.linear_speed = wfpi_pkg::SPEED_CRAWL;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (fire)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            started_reg    <= 1'b0;
            wait_count_reg <= 12'd0;
            error_sum_reg  <= 32'sd0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (fire)
            begin
                started_reg    <= started_next;
                wait_count_reg <= wait_count_next;
                error_sum_reg  <= error_sum_next;
            end
        end
    end

    // Request payload
    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= in_data;
    end

endmodule

### design/wfpi_law.sv
// PI arithmetic pipeline: gain products, divide by ten, sum and saturate, result register.
module wfpi_law
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  wfpi_pkg::law_req_t  req,
    input  wfpi_pkg::cfg_t      cfg,
    output logic                out_valid,
    input  logic                out_stall,
    output wfpi_pkg::out_req_t  out_data
);

    // Stage valids and ready chain
    logic va_reg, vb_reg, vc_reg, vd_reg, vo_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;

    assign rdy_o     = !vo_reg || !out_stall;
    assign rdy_d     = !vd_reg || rdy_o;
    assign rdy_c     = !vc_reg || rdy_d;
    assign rdy_b     = !vb_reg || rdy_c;
    assign rdy_a     = !va_reg || rdy_b;
    assign req_ready = rdy_a;
    assign out_valid = vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a) va_reg <= req_valid;
            if (rdy_b) vb_reg <= va_reg;
            if (rdy_c) vc_reg <= vb_reg;
            if (rdy_d) vd_reg <= vc_reg;
            if (rdy_o) vo_reg <= vd_reg;
        end
    end

    // Stage A: latched request
    wfpi_pkg::law_req_t a_reg;

    // A -> B: proportional product, |sum| and |sum|/10
    logic signed [24:0] prop_a;
    logic [31:0]        mag_a;
    logic [63:0]        recip_prod;
    logic [28:0]        quot_a;

    assign prop_a     = 25'(a_reg.err) * 25'(cfg.gain_prop);
    assign mag_a      = a_reg.sum[31] ? (~a_reg.sum + 32'd1) : a_reg.sum;
    assign recip_prod = {32'd0, mag_a} * {32'd0, wfpi_pkg::RECIP_TEN};
    assign quot_a     = recip_prod[63:35];

    logic [11:0]        b_lin_reg;
    logic [1:0]         b_phase_reg;
    logic signed [24:0] b_prop_reg;
    logic [31:0]        b_mag_reg;
    logic [28:0]        b_quot_reg;
    logic               b_neg_reg;

    // B -> C: remainder, quotient and remainder times |gain|
    logic [7:0]  kmag;
    logic [31:0] ten_q;
    logic [31:0] rem_wide;
    logic [3:0]  rem_b;
    logic [36:0] qk_b;
    logic [10:0] rk_b;

    assign kmag     = cfg.gain_integ[7] ? (~cfg.gain_integ + 8'd1) : cfg.gain_integ;
    assign ten_q    = {b_quot_reg, 3'b000} + {2'b00, b_quot_reg, 1'b0};
    assign rem_wide = b_mag_reg - ten_q;
    assign rem_b    = rem_wide[3:0];
    assign qk_b     = 37'(b_quot_reg) * 37'(kmag);
    assign rk_b     = 11'(rem_b) * 11'(kmag);

    logic [11:0]        c_lin_reg;
    logic [1:0]         c_phase_reg;
    logic signed [24:0] c_prop_reg;
    logic [36:0]        c_qk_reg;
    logic [10:0]        c_rk_reg;
    logic               c_neg_reg;

    // C -> D: remainder part over ten, integral magnitude
    logic [23:0] rk_prod;
    logic [36:0] integ_c;

    assign rk_prod = 24'(c_rk_reg) * 24'(wfpi_pkg::RECIP_TEN_SMALL);
    assign integ_c = c_qk_reg + 37'(rk_prod[23:16]);

    logic [11:0]        d_lin_reg;
    logic [1:0]         d_phase_reg;
    logic signed [24:0] d_prop_reg;
    logic [36:0]        d_integ_reg;
    logic               d_neg_reg;

    // D -> out: combine terms, saturate, select by phase
    logic signed [39:0] integ_s;
    logic signed [39:0] total;
    logic signed [23:0] ang_sat;
    logic signed [23:0] ang_d;

    assign integ_s = $signed({3'b000, d_integ_reg});
    assign total   = 40'(d_prop_reg) + (d_neg_reg ? -integ_s : integ_s);

    always_comb
    begin
        priority if (total > 40'(wfpi_pkg::ANG_MAX))
            ang_sat = wfpi_pkg::ANG_MAX;
        else if (total < 40'(wfpi_pkg::ANG_MIN))
            ang_sat = wfpi_pkg::ANG_MIN;
        else
            ang_sat = total[23:0];
    end

    always_comb
    begin
        unique case (d_phase_reg)
            wfpi_pkg::PHASE_WAIT:     ang_d = wfpi_pkg::ANG_ZERO;
            wfpi_pkg::PHASE_APPROACH: ang_d = wfpi_pkg::ANG_ZERO;
            wfpi_pkg::PHASE_FOLLOW:   ang_d = ang_sat;
            wfpi_pkg::PHASE_AVOID:    ang_d = wfpi_pkg::TURN_RATE;
        endcase
    end

    wfpi_pkg::out_req_t out_reg;
    assign out_data = out_reg;

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy_a)
            a_reg <= req;
        if (rdy_b)
        begin
            b_lin_reg   <= a_reg.linear_speed;
            b_phase_reg <= a_reg.phase;
            b_prop_reg  <= prop_a;
            b_mag_reg   <= mag_a;
            b_quot_reg  <= quot_a;
            b_neg_reg   <= a_reg.sum[31];
        end
        if (rdy_c)
        begin
            c_lin_reg   <= b_lin_reg;
            c_phase_reg <= b_phase_reg;
            c_prop_reg  <= b_prop_reg;
            c_qk_reg    <= qk_b;
            c_rk_reg    <= rk_b;
            c_neg_reg   <= b_neg_reg ^ cfg.gain_integ[7];
        end
        if (rdy_d)
        begin
            d_lin_reg   <= c_lin_reg;
            d_phase_reg <= c_phase_reg;
            d_prop_reg  <= c_prop_reg;
            d_integ_reg <= integ_c;
            d_neg_reg   <= c_neg_reg;
        end
        if (rdy_o)
        begin
            out_reg.linear_speed  <= d_lin_reg;
            out_reg.angular_speed <= ang_d;
            out_reg.phase         <= d_phase_reg;
        end
    end

endmodule

### design/wall_follow_pi_controller.sv
// Wall-following PI controller; every accepted request yields one result.
// One request per cycle unless stalled; a request may enter while a result stalls.
// The error-sum loop closes in the phase stage; the gain and divide-by-ten work runs in
// five further pipeline stages, and the last of them is the result register.
// Reset (async, active low) clears the startup count, the started flag, the error sum,
// all stage valids and restores the configuration registers to their defaults.
module wall_follow_pi_controller
#(
    parameter int unsigned STARTUP_TICKS = 300
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  wfpi_pkg::in_req_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output wfpi_pkg::out_req_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [11:0] STARTUP_CNT = 12'(STARTUP_TICKS);

    wfpi_pkg::cfg_t     cfg;
    logic               law_valid;
    logic               law_ready;
    wfpi_pkg::law_req_t law_req;

    wfpi_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wfpi_ctrl #(.STARTUP_CNT(STARTUP_CNT)) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg       (cfg),
        .law_ready (law_ready),
        .law_valid (law_valid),
        .law_req   (law_req)
    );

    wfpi_law u_law
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (law_valid),
        .req_ready (law_ready),
        .req       (law_req),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### design/wfpi_checker.sv
// Port-level checks on the controller results, bound to the top level.
module wfpi_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input wfpi_pkg::out_req_t out_data
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Waiting commands zero speed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.phase == wfpi_pkg::PHASE_WAIT |->
        out_data.linear_speed == wfpi_pkg::SPEED_ZERO &&
        out_data.angular_speed == wfpi_pkg::ANG_ZERO)
        else $error("waiting result not zero");

    // Approach drives straight, moving or stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.phase == wfpi_pkg::PHASE_APPROACH |->
        out_data.angular_speed == wfpi_pkg::ANG_ZERO &&
        (out_data.linear_speed == wfpi_pkg::SPEED_ZERO ||
         out_data.linear_speed == wfpi_pkg::SPEED_APPROACH))
        else $error("bad approach result");

    // Following uses one of the two following speeds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.phase == wfpi_pkg::PHASE_FOLLOW |->
        out_data.linear_speed == wfpi_pkg::SPEED_SLOW ||
        out_data.linear_speed == wfpi_pkg::SPEED_FAST)
        else $error("bad following speed");

    // Avoidance is a fixed crawl and turn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.phase == wfpi_pkg::PHASE_AVOID |->
        out_data.linear_speed == wfpi_pkg::SPEED_CRAWL &&
        out_data.angular_speed == wfpi_pkg::TURN_RATE)
        else $error("bad avoidance result");

endmodule

bind wall_follow_pi_controller wfpi_checker u_wfpi_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
